### rtl/gcpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpc_pkg
// Shared types and constants of the graph cycle parity checker.
// ----------------------------------------------------------------------------
package gcpc_pkg;

  localparam int unsigned INPUT_BONDS = 4;
  localparam int unsigned TAG_W = 8;
  localparam int unsigned ID_W = 16;
  localparam int unsigned DEG_W = 3;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned CNT_W = 9;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_RUN  = 1'b1
  } cmd_t;

  // one classified item passed from the front end to the walk engine
  typedef struct packed {
    cmd_t                   cmd;
    logic [IDX_W-1:0]       idx;
    logic [TAG_W-1:0]       tag;
    logic [DEG_W-1:0]       deg;
    logic [INPUT_BONDS*ID_W-1:0] nbrs;
  } job_t;

endpackage

### rtl/gcpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpc_front
// Input stage: unpack, saturate bond count, drop out-of-range loads, and
// queue jobs in a two-entry FIFO for the walk engine.
// ----------------------------------------------------------------------------
module gcpc_front #(
  parameter int unsigned MAX_NODES = 256,
  parameter int unsigned MAX_BONDS = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic            in_tuser,
  input  logic [87:0]     in_tdata,
  output logic            job_valid,
  input  logic            job_ready,
  output gcpc_pkg::job_t  job
);
  import gcpc_pkg::*;

  localparam int unsigned LIMIT = (MAX_BONDS < INPUT_BONDS) ? MAX_BONDS : INPUT_BONDS;

  job_t        q_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  job_t        cls;
  logic        keep;
  logic        push, pop;

  always_comb begin
    cls.cmd  = cmd_t'(in_tuser);
    cls.idx  = in_tdata[7:0];
    cls.tag  = in_tdata[15:8];
    cls.deg  = (32'(in_tdata[18:16]) > LIMIT) ? DEG_W'(LIMIT) : in_tdata[18:16];
    cls.nbrs = in_tdata[82:19];
    // drop loads whose index is beyond the node store
    keep = (cls.cmd == CMD_RUN) || (32'(cls.idx) < MAX_NODES);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && keep;
  assign job_valid = (cnt_r != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

### rtl/gcpc_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpc_walk
// Back end: node stores, iterative depth-first walk with explicit stack,
// cycle tag parity scan, and a one-entry result register.
// ----------------------------------------------------------------------------
module gcpc_walk #(
  parameter int unsigned MAX_NODES = 256,
  parameter int unsigned MAX_BONDS = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [8:0]      cfg_nodes,
  input  logic            job_valid,
  output logic            job_ready,
  input  gcpc_pkg::job_t  job,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic            out_graph_valid
);
  import gcpc_pkg::*;

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned DW  = $clog2(MAX_NODES + 1);
  localparam int unsigned BW  = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;
  localparam int unsigned CW  = $clog2(MAX_BONDS + 1);
  localparam int unsigned NBW = $clog2(MAX_NODES * MAX_BONDS);
  localparam int unsigned LOADS = (MAX_BONDS < INPUT_BONDS) ? MAX_BONDS : INPUT_BONDS;

  typedef enum logic [3:0] {
    S_IDLE, S_LOADN, S_CLEAR, S_SCAN, S_TOP, S_BOND, S_TEST,
    S_PSEEK, S_PACC, S_PTAG, S_DONE
  } state_t;

  // memories
  logic [TAG_W-1:0] tag_mem  [MAX_NODES];
  logic [DEG_W-1:0] deg_mem  [MAX_NODES];
  logic [ID_W-1:0]  nb_mem   [MAX_NODES*MAX_BONDS];
  logic [NW-1:0]    stk_mem  [MAX_NODES];
  logic [CW-1:0]    cur_mem  [MAX_NODES];
  logic             vis_mem  [MAX_NODES];
  logic             onp_mem  [MAX_NODES];

  state_t           st_r;
  logic [DW-1:0]    cnt_r;
  logic [DW-1:0]    root_r;
  logic [DW-1:0]    dep_r;
  logic [NW-1:0]    cur_r, par_r;
  logic [CW-1:0]    bc_r;
  logic [DEG_W-1:0] deg_r;
  logic [ID_W-1:0]  nb_r;
  logic [DW-1:0]    j_r;
  logic [TAG_W-1:0] acc_r;
  logic [NW-1:0]    tgt_r;
  logic             scan_on_r;
  logic [BW-1:0]    lslot_r;
  logic [NW-1:0]    ld_idx_r;
  logic [INPUT_BONDS*ID_W-1:0] ld_nbrs_r;
  logic             vrd_r;
  logic             res_r;
  logic             ov_r;
  logic             post;
  // registered reads
  logic             vis_q, onp_q;
  logic [NW-1:0]    stk_q;
  logic [TAG_W-1:0] tag_q;

  // flat neighbor slot address: node * MAX_BONDS + slot
  function automatic logic [NBW-1:0] nb_addr(input logic [NW-1:0] node,
                                             input logic [BW-1:0] slot);
    return NBW'(node) * NBW'(MAX_BONDS) + NBW'(slot);
  endfunction

  assign job_ready       = (st_r == S_IDLE);
  assign out_tvalid      = ov_r;
  assign out_graph_valid = res_r;
  assign post            = (st_r == S_DONE) && (!ov_r || out_tready);

  logic [DW-1:0] lim;
  assign lim = (32'(cfg_nodes) > MAX_NODES) ? DW'(MAX_NODES) : DW'(cfg_nodes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (post) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (job_valid) begin
            ld_idx_r  <= NW'(job.idx);
            ld_nbrs_r <= job.nbrs;
            lslot_r   <= '0;
            if (job.cmd == CMD_LOAD) begin
              tag_mem[NW'(job.idx)] <= job.tag;
              deg_mem[NW'(job.idx)] <= job.deg;
              st_r <= S_LOADN;
            end else begin
              cnt_r  <= lim;
              root_r <= '0;
              st_r   <= S_CLEAR;
            end
          end
        end
        S_LOADN: begin
          // write one neighbor slot per cycle
          nb_mem[nb_addr(ld_idx_r, lslot_r)] <=
            (32'(lslot_r) < LOADS) ? ld_nbrs_r[32'(lslot_r)*ID_W +: ID_W] : '0;
          lslot_r <= lslot_r + 1'b1;
          if (32'(lslot_r) == MAX_BONDS - 1) st_r <= S_IDLE;
        end
        S_CLEAR: begin
          // sweep marks clear, one node a cycle
          vis_mem[root_r[NW-1:0]] <= 1'b0;
          onp_mem[root_r[NW-1:0]] <= 1'b0;
          if (32'(root_r) == MAX_NODES - 1) begin
            root_r    <= '0;
            dep_r     <= '0;
            scan_on_r <= 1'b0;
            st_r      <= S_SCAN;
          end else begin
            root_r <= root_r + 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_on_r) begin
            scan_on_r <= 1'b0;
            if (vis_q) begin
              root_r <= root_r + 1'b1;
            end else begin
              vis_mem[root_r[NW-1:0]] <= 1'b1;
              onp_mem[root_r[NW-1:0]] <= 1'b1;
              stk_mem[0] <= root_r[NW-1:0];
              cur_mem[0] <= '0;
              dep_r <= DW'(1);
              root_r <= root_r + 1'b1;
              st_r <= S_TOP;
            end
          end else if (root_r >= cnt_r) begin
            vrd_r <= 1'b1;
            st_r  <= S_DONE;
          end else begin
            vis_q     <= vis_mem[root_r[NW-1:0]];
            scan_on_r <= 1'b1;
          end
        end
        S_TOP: begin
          if (dep_r == '0) begin
            st_r <= S_SCAN;
          end else begin
            cur_r <= stk_mem[NW'(dep_r - 1'b1)];
            par_r <= stk_mem[NW'(dep_r - 2'd2)];
            bc_r  <= cur_mem[NW'(dep_r - 1'b1)];
            st_r  <= S_BOND;
            scan_on_r <= 1'b0;
          end
        end
        S_BOND: begin
          if (!scan_on_r) begin
            deg_r <= deg_mem[cur_r];
            nb_r  <= nb_mem[nb_addr(cur_r, bc_r[BW-1:0])];
            scan_on_r <= 1'b1;
          end else begin
            scan_on_r <= 1'b0;
            if (32'(bc_r) < 32'(deg_r) && 32'(bc_r) < MAX_BONDS) begin
              cur_mem[NW'(dep_r - 1'b1)] <= bc_r + 1'b1;
              if (32'(nb_r) >= 32'(cnt_r)) begin
                st_r <= S_TOP;
              end else begin
                vis_q <= vis_mem[nb_r[NW-1:0]];
                onp_q <= onp_mem[nb_r[NW-1:0]];
                st_r  <= S_TEST;
              end
            end else begin
              onp_mem[cur_r] <= 1'b0;
              dep_r <= dep_r - 1'b1;
              st_r  <= S_TOP;
            end
          end
        end
        S_TEST: begin
          if (!vis_q) begin
            vis_mem[nb_r[NW-1:0]] <= 1'b1;
            onp_mem[nb_r[NW-1:0]] <= 1'b1;
            stk_mem[NW'(dep_r)] <= nb_r[NW-1:0];
            cur_mem[NW'(dep_r)] <= '0;
            dep_r <= dep_r + 1'b1;
            st_r  <= S_TOP;
          end else if (onp_q && !((dep_r > DW'(1)) && (nb_r[NW-1:0] == par_r))) begin
            tgt_r <= nb_r[NW-1:0];
            j_r   <= '0;
            acc_r <= '0;
            scan_on_r <= 1'b0;
            st_r  <= S_PSEEK;
          end else begin
            st_r <= S_TOP;
          end
        end
        S_PSEEK: begin
          // find target's place on the path, reading one stack entry after another
          if (!scan_on_r) begin
            stk_q <= stk_mem[NW'(j_r)];
            scan_on_r <= 1'b1;
          end else begin
            scan_on_r <= 1'b0;
            if (stk_q == tgt_r) begin
              st_r <= S_PACC;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
        end
        S_PACC: begin
          if (j_r >= dep_r) begin
            if (acc_r != '0) begin
              vrd_r <= 1'b0;
              st_r  <= S_DONE;
            end else begin
              st_r <= S_TOP;
            end
          end else begin
            stk_q <= stk_mem[NW'(j_r)];
            st_r  <= S_PTAG;
            scan_on_r <= 1'b0;
          end
        end
        S_PTAG: begin
          if (!scan_on_r) begin
            tag_q <= tag_mem[stk_q];
            scan_on_r <= 1'b1;
          end else begin
            acc_r <= acc_r ^ tag_q;
            j_r   <= j_r + 1'b1;
            st_r  <= S_PACC;
          end
        end
        S_DONE: begin
          // hold the verdict until the result register is free
          if (post) begin
            res_r <= vrd_r;
            st_r  <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/graph_cycle_parity_checker.sv
`timescale 1ns / 1ps
// Order: an item is registered in the front queue; a load then holds the engine while
// it writes one neighbor slot per cycle. A run clears the marks, then scans the roots,
// reads each bond, pops finished nodes, searches the path and XORs its entries in a
// cycle scan, and finally posts the verdict to the result register.
// Throughput: one item at a time in the engine; the queue holds two, the result one.
// Reset (rst_n low, synchronous) empties the queue, idles the engine, clears nodes_in_use.
// ----------------------------------------------------------------------------
// graph_cycle_parity_checker
// Top level: config register, front end with job queue, and walk engine.
// ----------------------------------------------------------------------------
module graph_cycle_parity_checker #(
  parameter int unsigned MAX_NODES = 256,
  parameter int unsigned MAX_BONDS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,     // nodes_in_use
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,      // [0] command
  // [7:0] node_index, [15:8] node_tag, [18:16] bond_total,
  // [34:19] neighbor_a, [50:35] neighbor_b, [66:51] neighbor_c,
  // [82:67] neighbor_d, [87:83] zero
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata      // [0] graph_valid, [7:1] zero
);
  import gcpc_pkg::*;

  logic [8:0] nodes_r;
  logic       job_valid, job_ready;
  job_t       job;
  logic       gv;

  // hold nodes_in_use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r <= '0;
    end else if (cfg_we) begin
      nodes_r <= cfg_wdata;
    end
  end

  gcpc_front #(.MAX_NODES(MAX_NODES), .MAX_BONDS(MAX_BONDS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  gcpc_walk #(.MAX_NODES(MAX_NODES), .MAX_BONDS(MAX_BONDS)) u_walk (
    .clk(clk), .rst_n(rst_n), .cfg_nodes(nodes_r),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_graph_valid(gv)
  );

  assign out_tdata = {7'd0, gv};

endmodule

### bench/gcpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpc_checker
// Watches the load/run stream, predicts the verdict of every run with its own
// copy of the node stores, and compares each result transfer in order.
// ----------------------------------------------------------------------------
module gcpc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        in_tuser,
  input  logic [87:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  output int          errors,
  output int          verdicts_pending,
  output int          verdicts_seen
);
  import gcpc_pkg::*;

  logic [TAG_W-1:0] tag_mem [256];
  logic [DEG_W-1:0] deg_mem [256];
  logic [ID_W-1:0]  nbr_mem [1024];
  logic [CNT_W-1:0] walk_count;
  bit               verdict_q[$];

  // depth-first walk over nodes below the count, checking every closed cycle
  function automatic bit walk_graph(int unsigned cnt_in);
    bit          seen [256];
    bit          onp [256];
    int unsigned stk [256];
    int unsigned cursor [256];
    int unsigned cnt, depth, i, j, pos, cur, nb;
    logic [7:0]  acc;
    cnt = (cnt_in > 256) ? 256 : cnt_in;
    depth = 0;
    for (i = 0; i < 256; i++) begin
      seen[i] = 0;
      onp[i] = 0;
    end
    for (i = 0; i < cnt; i++) begin
      if (seen[i]) continue;
      seen[i] = 1; onp[i] = 1; stk[0] = i; cursor[0] = 0; depth = 1;
      while (depth > 0) begin
        pos = depth - 1;
        cur = stk[pos];
        if (cursor[pos] < deg_mem[cur]) begin
          nb = nbr_mem[cur*4 + cursor[pos]];
          cursor[pos]++;
          if (nb >= cnt) continue;
          if (!seen[nb]) begin
            seen[nb] = 1; onp[nb] = 1;
            stk[depth] = nb; cursor[depth] = 0; depth++;
          end else if (onp[nb] && !(pos > 0 && nb == stk[pos-1])) begin
            j = 0;
            while (j < depth && stk[j] != nb) j++;
            acc = '0;
            for (; j < depth; j++) acc ^= tag_mem[stk[j]];
            if (acc != 0) return 1'b0;
          end
        end else begin
          onp[cur] = 0;
          depth--;
        end
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    logic [DEG_W-1:0] bt;
    bit exp_v;
    if (!rst_n) begin
      verdict_q.delete();
      walk_count = '0;
      errors = errors;
    end else begin
      if (cfg_we) walk_count = cfg_wdata;
      if (in_tvalid && in_tready) begin
        if (cmd_t'(in_tuser) == CMD_LOAD) begin
          bt = in_tdata[18:16];
          tag_mem[in_tdata[7:0]] = in_tdata[15:8];
          deg_mem[in_tdata[7:0]] = (bt > INPUT_BONDS) ? DEG_W'(INPUT_BONDS) : bt;
          for (int k = 0; k < 4; k++)
            nbr_mem[in_tdata[7:0]*4 + k] = in_tdata[19 + k*16 +: 16];
        end else begin
          verdict_q.push_back(walk_graph(walk_count));
        end
      end
      if (out_tvalid && out_tready) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual %h", $time, out_tdata);
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_tdata !== {7'b0, exp_v}) begin
            errors++;
            $display("%0t: graph_valid mismatch, expected %h actual %h",
                     $time, {7'b0, exp_v}, out_tdata);
          end
        end
      end
    end
    verdicts_pending = verdict_q.size();
  end

  initial begin
    errors = 0;
    verdicts_pending = 0;
    verdicts_seen = 0;
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Graph cycle parity checker bench: loads node entries, writes the node count
// between phases and launches runs under several idle/stall patterns.
// ----------------------------------------------------------------------------
module tb;
  import gcpc_pkg::*;

  localparam longint CYCLE_LIMIT = 50000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        in_fire_q;

  int          errors, verdicts_pending, verdicts_seen;
  int          tx_pct, rx_pct;
  bit          drain_before_run;
  bit          loaded [256];
  int          n_loads, n_runs;
  longint      cycles;

  graph_cycle_parity_checker dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  gcpc_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .verdicts_pending(verdicts_pending),
    .verdicts_seen(verdicts_seen)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // remember the handshake of the last edge so the driver can act on it at
  // the following falling edge
  always @(posedge clk) in_fire_q <= in_tvalid & in_tready;

  // receiver: stall at the rate of the current phase
  always @(negedge clk)
    out_tready <= ($urandom_range(99) < rx_pct) ? 1'b0 : 1'b1;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // drive one item; valid stays high into the next call
  task automatic push_item(cmd_t cmd, logic [7:0] idx, logic [7:0] tag,
                           logic [2:0] bt, logic [15:0] na, logic [15:0] nb,
                           logic [15:0] nc, logic [15:0] nd);
    if (cmd == CMD_RUN && drain_before_run) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
      while (verdicts_pending != 0) @(negedge clk);
    end
    while ($urandom_range(99) < tx_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, nd, nc, nb, na, bt, tag, idx};
    do @(negedge clk); while (!in_fire_q);
    if (cmd == CMD_LOAD) begin
      loaded[idx] = 1;
      n_loads++;
    end else begin
      n_runs++;
    end
  endtask

  task automatic run_graph();
    push_item(CMD_RUN, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom);
  endtask

  // hold until every verdict is back, let trailing loads finish, then write
  task automatic set_node_count(int unsigned cnt);
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (verdicts_pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cnt[8:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int loaded_prefix();
    int p;
    p = 0;
    while (p < 256 && loaded[p]) p++;
    return p;
  endfunction

  // neighbor id: mostly a live node, sometimes self, sometimes anything
  function automatic logic [15:0] pick_neighbor(int unsigned cnt, logic [7:0] self);
    int r, lim;
    r = $urandom_range(99);
    lim = (cnt > 256) ? 256 : cnt;
    if (r < 70 && lim > 0) return 16'($urandom_range(lim - 1));
    if (r < 80) return {8'b0, self};
    return 16'($urandom);
  endfunction

  task automatic random_load(int unsigned cnt, logic [7:0] idx);
    logic [7:0] tag;
    tag = ($urandom_range(99) < 65) ? 8'h00 : 8'($urandom);
    push_item(CMD_LOAD, idx, tag, 3'($urandom_range(7)),
              pick_neighbor(cnt, idx), pick_neighbor(cnt, idx),
              pick_neighbor(cnt, idx), pick_neighbor(cnt, idx));
  endtask

  initial begin
    int unsigned cnt, span, prefix;
    logic [7:0] idx;
    cycles = 0;
    tx_pct = 0; rx_pct = 0; drain_before_run = 0;
    n_loads = 0; n_runs = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tuser = 1'b0; in_tdata = '0; out_tready = 1'b1;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty graph, balanced triangle, self bond, extremes
    set_node_count(0);
    run_graph();
    push_item(CMD_LOAD, 8'd0, 8'h0F, 3'd2, 16'd1, 16'd2, 16'd0, 16'd0);
    push_item(CMD_LOAD, 8'd1, 8'hF0, 3'd2, 16'd0, 16'd2, 16'd0, 16'd0);
    push_item(CMD_LOAD, 8'd2, 8'hFF, 3'd2, 16'd0, 16'd1, 16'd0, 16'd0);
    push_item(CMD_LOAD, 8'd3, 8'h05, 3'd1, 16'd3, 16'd0, 16'd0, 16'd0);
    set_node_count(3);
    run_graph();
    set_node_count(4);
    run_graph();                       // self bond with nonzero tag
    push_item(CMD_LOAD, 8'd3, 8'h00, 3'd7, 16'd3, 16'hFFFF, 16'd0, 16'd2);
    run_graph();                       // saturated bonds, out-of-range id
    push_item(CMD_LOAD, 8'd255, 8'hFF, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF);
    push_item(CMD_LOAD, 8'd2, 8'hF0, 3'd4, 16'd1, 16'd3, 16'd0, 16'd2);
    run_graph();                       // broken triangle parity
    push_item(CMD_LOAD, 8'd1, 8'h00, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_graph();                       // node 1 reloaded with no bonds

    // random phases
    for (int p = 0; p < 12; p++) begin
      unique case (p % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 78; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 78; end
        default: begin tx_pct = 9; rx_pct = 9; end
      endcase
      drain_before_run = (p == 2);
      if (p == 4) begin
        // fill every entry so the full count can be used
        set_node_count(256);
        for (int n = 0; n < 256; n++) random_load(256, 8'(n));
        cnt = 256;
      end else if (p == 8) begin
        cnt = 511;                      // count above the store size
      end else begin
        prefix = loaded_prefix();
        cnt = ($urandom_range(9) == 0) ? prefix
                                       : $urandom_range((prefix < 24) ? prefix : 24);
      end
      set_node_count(cnt);
      span = ((cnt > 250) ? 255 : cnt + 4);
      for (int it = 0; it < 120; it++) begin
        // keep full-size walks rare, they are long
        if ($urandom_range(99) < ((cnt > 24) ? 2 : 18)) begin
          run_graph();
        end else begin
          idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(span));
          random_load(cnt, idx);
        end
      end
      run_graph();
    end

    in_tvalid <= 1'b0;
    @(negedge clk);
    while (verdicts_pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Covered %0d node loads and %0d graph runs, %0d verdicts checked,",
             n_loads, n_runs, verdicts_seen);
    $display("node counts from 0 to 511 under four idle/stall patterns.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/gcpc_pkg.sv
rtl/gcpc_front.sv
rtl/gcpc_walk.sv
rtl/graph_cycle_parity_checker.sv
bench/gcpc_checker.sv
bench/tb.sv
